// ===== rtl/core/pbc_pkg.sv =====
package pbc_pkg;

	localparam int BLOCK_W   = 64;
	localparam int KEY_DEPTH = 32;
	localparam int KA_W      = $clog2(KEY_DEPTH);
	localparam int CFG_IDX_W = 2;
	localparam int ROUNDS_DEF = 31;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_MODE = 2'd2;

	typedef struct packed {
		logic            key_load;
		logic            key_step;
		logic            key_we;
		logic [KA_W-1:0] key_waddr;
		logic [KA_W-1:0] key_raddr;
		logic            blk_load;
		logic            blk_round;
		logic            blk_final;
		logic            dec;
	} pbc_cmd_t;

endpackage

// ===== rtl/core/pbc_ram.sv =====
module pbc_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/core/pbc_ctrl.sv =====
module pbc_ctrl #(
	parameter int ROUNDS = pbc_pkg::ROUNDS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic                             op,
	input  logic                             cfg_we,
	input  logic [pbc_pkg::CFG_IDX_W-1:0]    cfg_index,
	output logic                             busy,
	output logic                             done,
	output pbc_pkg::pbc_cmd_t                cmd
);

	localparam int RCW = (ROUNDS > 1) ? $clog2(ROUNDS + 1) : 1;
	localparam int KAW = pbc_pkg::KA_W;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_KLOAD,
		ST_KGEN,
		ST_RUN
	} state_t;

	state_t         state_q;
	logic [RCW-1:0] rcnt_q;
	logic [KAW-1:0] kaddr_q;
	logic [KAW-1:0] kidx_q;
	logic           dec_q;
	logic           done_q;
	logic           cfg_hit;
	logic           last_round;

	assign cfg_hit = cfg_we && (cfg_index inside {pbc_pkg::REG_KEY_HIGH,
		pbc_pkg::REG_KEY_LOW, pbc_pkg::REG_KEY_MODE});
	assign last_round = (rcnt_q == RCW'(ROUNDS));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			rcnt_q  <= '0;
			kaddr_q <= '0;
			kidx_q  <= '0;
			dec_q   <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (cfg_hit) begin
				// any key write restarts the schedule from the new key
				state_q <= ST_KLOAD;
			end else begin
				case (state_q)
					ST_IDLE: begin
						if (start) begin
							state_q <= ST_RUN;
							rcnt_q  <= '0;
							dec_q   <= op;
							// address 0 / ROUNDS is read at the request edge
							kaddr_q <= op ? KAW'(ROUNDS - 1) : KAW'(1);
						end
					end
					ST_KLOAD: begin
						state_q <= ST_KGEN;
						kidx_q  <= '0;
					end
					ST_KGEN: begin
						kidx_q <= kidx_q + 1'b1;
						if (kidx_q == KAW'(pbc_pkg::KEY_DEPTH - 1)) begin
							state_q <= ST_IDLE;
						end
					end
					ST_RUN: begin
						kaddr_q <= dec_q ? kaddr_q - 1'b1 : kaddr_q + 1'b1;
						if (last_round) begin
							state_q <= ST_IDLE;
							done_q  <= 1'b1;
						end else begin
							rcnt_q <= rcnt_q + 1'b1;
						end
					end
					default: begin
						state_q <= ST_IDLE;
					end
				endcase
			end
		end
	end

	assign busy = (state_q != ST_IDLE);
	assign done = done_q;

	always_comb begin
		cmd           = '0;
		cmd.key_load  = (state_q == ST_KLOAD);
		cmd.key_step  = (state_q == ST_KGEN);
		cmd.key_we    = (state_q == ST_KGEN);
		cmd.key_waddr = kidx_q;
		cmd.key_raddr = (state_q == ST_IDLE) ? (op ? KAW'(ROUNDS) : '0) : kaddr_q;
		cmd.blk_load  = (state_q == ST_IDLE) && start;
		cmd.blk_round = (state_q == ST_RUN) && !last_round;
		cmd.blk_final = (state_q == ST_RUN) && last_round;
		cmd.dec       = dec_q;
	end

`ifndef SYNTHESIS
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done held for more than one cycle");
	a_done_after_run: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("done without a preceding run");
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("request accepted but block not busy");
	a_key_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_hit |=> (busy && !done))
		else $error("key write did not start the schedule");
	a_rcnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		rcnt_q <= RCW'(ROUNDS))
		else $error("round counter past last round");
`endif

endmodule

// ===== rtl/core/pbc_datapath.sv =====
module pbc_datapath (
	input  logic                             clk,
	input  logic                             arst_n,
	input  pbc_pkg::pbc_cmd_t                cmd,
	input  logic                             cfg_we,
	input  logic [pbc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [pbc_pkg::BLOCK_W-1:0]      cfg_data,
	input  logic [pbc_pkg::BLOCK_W-1:0]      block_in,
	output logic [pbc_pkg::BLOCK_W-1:0]      block_out
);

	localparam int W = pbc_pkg::BLOCK_W;

	function automatic logic [3:0] sbox(input logic [3:0] x);
		logic [3:0] y;
		case (x)
			4'h0: y = 4'hC;
			4'h1: y = 4'h5;
			4'h2: y = 4'h6;
			4'h3: y = 4'hB;
			4'h4: y = 4'h9;
			4'h5: y = 4'h0;
			4'h6: y = 4'hA;
			4'h7: y = 4'hD;
			4'h8: y = 4'h3;
			4'h9: y = 4'hE;
			4'hA: y = 4'hF;
			4'hB: y = 4'h8;
			4'hC: y = 4'h4;
			4'hD: y = 4'h7;
			4'hE: y = 4'h1;
			4'hF: y = 4'h2;
			default: y = 4'h0;
		endcase
		return y;
	endfunction

	function automatic logic [3:0] sbox_inv(input logic [3:0] x);
		logic [3:0] y;
		case (x)
			4'h0: y = 4'h5;
			4'h1: y = 4'hE;
			4'h2: y = 4'hF;
			4'h3: y = 4'h8;
			4'h4: y = 4'hC;
			4'h5: y = 4'h1;
			4'h6: y = 4'h2;
			4'h7: y = 4'hD;
			4'h8: y = 4'hB;
			4'h9: y = 4'h4;
			4'hA: y = 4'h6;
			4'hB: y = 4'h3;
			4'hC: y = 4'h0;
			4'hD: y = 4'h7;
			4'hE: y = 4'h9;
			4'hF: y = 4'hA;
			default: y = 4'h0;
		endcase
		return y;
	endfunction

	function automatic logic [W-1:0] enc_round(input logic [W-1:0] s);
		logic [W-1:0] t;
		logic [W-1:0] r;
		for (int n = 0; n < 16; n++) begin
			t[4*n +: 4] = sbox(s[4*n +: 4]);
		end
		// bit i moves to 16*i mod 63, bit 63 stays
		for (int i = 0; i < 63; i++) begin
			r[(16 * i) % 63] = t[i];
		end
		r[63] = t[63];
		return r;
	endfunction

	function automatic logic [W-1:0] dec_round(input logic [W-1:0] s);
		logic [W-1:0] t;
		logic [W-1:0] r;
		for (int i = 0; i < 63; i++) begin
			t[i] = s[(16 * i) % 63];
		end
		t[63] = s[63];
		for (int n = 0; n < 16; n++) begin
			r[4*n +: 4] = sbox_inv(t[4*n +: 4]);
		end
		return r;
	endfunction

	// one key schedule update; returns {hi, lo}
	function automatic logic [2*W-1:0] key_next(input logic [W-1:0] hi,
		input logic [W-1:0] lo, input logic is128, input logic [5:0] rc);
		logic [W-1:0] t;
		logic [W-1:0] nh;
		logic [W-1:0] nl;
		if (is128) begin
			t  = {hi[2:0], lo[63:3]};
			nl = {lo[2:0], hi[63:3]};
			nh = {sbox(t[63:60]), sbox(t[59:56]), t[55:0]};
			nh = nh ^ {60'd0, rc[5:2]};
			nl = nl ^ {rc[1:0], 62'd0};
		end else begin
			// 80-bit register: hi plus the top 16 bits of lo
			t  = {hi[2:0], lo[63:48], hi[63:19]};
			nl = {hi[18:3], 48'd0};
			nh = {sbox(t[63:60]), t[59:0]};
			nh = nh ^ {59'd0, rc[5:1]};
			nl = nl ^ {rc[0], 63'd0};
		end
		return {nh, nl};
	endfunction

	logic [W-1:0]   key_high_q;
	logic [W-1:0]   key_low_q;
	logic           key_is_128_q;
	logic [W-1:0]   kh_q;
	logic [W-1:0]   kl_q;
	logic [W-1:0]   st_q;
	logic [W-1:0]   out_q;
	logic [W-1:0]   rk;
	logic [W-1:0]   mix;
	logic [2*W-1:0] knext;
	logic [5:0]     rc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_high_q   <= '0;
			key_low_q    <= '0;
			key_is_128_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				pbc_pkg::REG_KEY_HIGH: key_high_q   <= cfg_data;
				pbc_pkg::REG_KEY_LOW:  key_low_q    <= cfg_data;
				pbc_pkg::REG_KEY_MODE: key_is_128_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign rc    = {1'b0, cmd.key_waddr} + 6'd1;
	assign knext = key_next(kh_q, kl_q, key_is_128_q, rc);

	always_ff @(posedge clk) begin
		if (cmd.key_load) begin
			kh_q <= key_high_q;
			kl_q <= key_is_128_q ? key_low_q : {key_low_q[63:48], 48'd0};
		end else if (cmd.key_step) begin
			kh_q <= knext[2*W-1:W];
			kl_q <= knext[W-1:0];
		end
	end

	pbc_ram #(
		.WIDTH (W),
		.DEPTH (pbc_pkg::KEY_DEPTH)
	) u_keys (
		.clk   (clk),
		.we    (cmd.key_we),
		.waddr (cmd.key_waddr),
		.wdata (kh_q),
		.raddr (cmd.key_raddr),
		.rdata (rk)
	);

	assign mix = st_q ^ rk;

	always_ff @(posedge clk) begin
		if (cmd.blk_load) begin
			st_q <= block_in;
		end else if (cmd.blk_round) begin
			st_q <= cmd.dec ? dec_round(mix) : enc_round(mix);
		end
		if (cmd.blk_final) begin
			out_q <= mix;
		end
	end

	assign block_out = out_q;

endmodule

// ===== rtl/core/present_block_cipher_unit.sv =====
// PRESENT 64-bit block cipher, 80- or 128-bit key.
//
// Configuration: write key_high (index 0), key_low (index 1) and key_is_128
// (index 2) through cfg_we/cfg_index/cfg_data while the block is idle. Each
// write restarts the key schedule: busy stays high while the key is loaded
// and the 32 round keys are written into the key RAM, one per cycle.
//
// Request: start is taken at a clock edge where busy is low and no key
// register is written; op selects encrypt (0) or decrypt (1), block_in
// carries the block. The core runs one round per cycle off the key RAM,
// then adds the last round key, with busy high throughout. The result
// appears on block_out with done high for exactly one cycle; busy drops in
// that same cycle, so a new request can be taken while done is high.
// There is no output stall; the receiver must take block_out while done.
//
// Reset (arst_n low) clears the key registers and the controller; the round
// key RAM is not cleared, so a key must be written before the first request.
module present_block_cipher_unit #(
	parameter int ROUNDS = pbc_pkg::ROUNDS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  logic                             op,
	input  logic [pbc_pkg::BLOCK_W-1:0]      block_in,
	output logic                             done,
	output logic [pbc_pkg::BLOCK_W-1:0]      block_out,
	input  logic                             cfg_we,
	input  logic [pbc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [pbc_pkg::BLOCK_W-1:0]      cfg_data
);

	pbc_pkg::pbc_cmd_t cmd;

	pbc_ctrl #(
		.ROUNDS (ROUNDS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.op        (op),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.busy      (busy),
		.done      (done),
		.cmd       (cmd)
	);

	pbc_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.block_in  (block_in),
		.block_out (block_out)
	);

endmodule
